@@ sv/ffba_pkg.sv @@
// Shared types and constants for the first-fit block allocator.
// Used by ffba_ctrl, ffba_dp and first_fit_block_allocator_core; no dependencies.
package ffba_pkg;

    localparam int ARENA_BYTES    = 1048576;
    localparam int HEADER_BYTES   = 32;
    localparam int ALIGN_BYTES    = 16;
    localparam int MAX_BLOCKS_DEF = 64;

    localparam int CMD_W  = 2;
    localparam int OFF_W  = 20;
    localparam int REQ_W  = 21;
    localparam int WANT_W = REQ_W + 1;
    localparam int SUM_W  = WANT_W + 1;
    localparam int STAT_W = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REALLOC = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_OOM     = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD_PTR = 2'd2;

    typedef struct packed {
        logic [OFF_W-1:0] start;
        logic [OFF_W-1:0] size;
        logic             free;
    } entry_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_INIT,
        OP_LATCH,
        OP_SCAN_ALLOC,
        OP_SCAN_FIND,
        OP_DECIDE,
        OP_UP_RD,
        OP_UP_WR,
        OP_WR_SPLIT,
        OP_WR_TAKE,
        OP_FWD_RD,
        OP_FWD_MERGE,
        OP_DN_RD,
        OP_DN_WR,
        OP_DEC,
        OP_BWD_RD,
        OP_BWD_MERGE,
        OP_FREE_WR,
        OP_RES_KEEP,
        OP_RES_OOM,
        OP_RES_BAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic find_hit;
        logic alloc_hit;
        logic scan_end;
        logic is_alloc;
        logic is_find;
        logic is_rptr;
        logic req_zero;
        logic fits;
        logic split;
        logic up_more;
        logic dn_more;
        logic fwd_more;
        logic bwd_more;
        logic rd_free;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_DECODE,
        S_ASCAN,
        S_FIND,
        S_FOUND,
        S_DECIDE,
        S_UP_TEST,
        S_UP_RD,
        S_UP_WR,
        S_WR_SPLIT,
        S_WR_TAKE,
        S_FWD_RD,
        S_FWD_CHK,
        S_DN_TEST,
        S_DN_RD,
        S_DN_WR,
        S_DN_DEC,
        S_BWD_RD,
        S_BWD_CHK,
        S_FREE_WR,
        S_KEEP,
        S_OOM,
        S_BAD,
        S_DONE
    } state_t;

endpackage

@@ sv/first_fit_block_allocator_core.sv @@
// First-fit block allocator: one command per transfer, one result strobed on done.
// An alloc scans the block table, writes a split block if one is made and moves entries up to make
// room; a free scans, moves entries down and merges with free neighbours; a realloc that moves its
// block adds a second scan and a free. One command at a time: busy stays high until done.
// After reset the init state writes the single free block (busy high). The receiver cannot
// stall: results are valid only while done is high.
module first_fit_block_allocator_core #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    output logic                        done,
    input  logic [ffba_pkg::CMD_W-1:0]  cmd,
    input  logic [ffba_pkg::REQ_W-1:0]  req_bytes,
    input  logic [ffba_pkg::OFF_W-1:0]  ptr_offset,
    input  logic                        ptr_valid,
    output logic [ffba_pkg::OFF_W-1:0]  res_offset,
    output logic                        res_valid,
    output logic [ffba_pkg::STAT_W-1:0] status
);
    import ffba_pkg::*;

    dp_cmd_t  ctl;
    dp_stat_t stat;

    ffba_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    ffba_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .stat       (stat),
        .cmd        (cmd),
        .req_bytes  (req_bytes),
        .ptr_offset (ptr_offset),
        .ptr_valid  (ptr_valid),
        .res_offset (res_offset),
        .res_valid  (res_valid),
        .status     (status)
    );

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("done without busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted transfer did not start work");

    a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && res_valid) |-> (status == ST_OK))
        else $error("returned block with error status");

    a_null_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !res_valid) |-> (res_offset == '0))
        else $error("null result with nonzero offset");

endmodule

@@ sv/ffba_ctrl.sv @@
// Command sequencer for the first-fit block allocator.
// Depends on ffba_pkg; drives ffba_dp through dp_cmd_t and reads dp_stat_t.
module ffba_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  ffba_pkg::dp_stat_t stat,
    output ffba_pkg::dp_cmd_t  ctl,
    output logic              busy,
    output logic              done
);
    import ffba_pkg::*;

    state_t state_reg, state_next;
    logic   back_reg, back_next;
    logic   again_reg, again_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            back_reg  <= 1'b0;
            again_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            back_reg  <= back_next;
            again_reg <= again_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        back_next  = back_reg;
        again_next = again_reg;
        case (state_reg)
            S_INIT:     state_next = S_IDLE;
            S_IDLE:
            begin
                if (start)
                begin
                    again_next = 1'b0;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_alloc)
                    state_next = S_ASCAN;
                else if (stat.is_find)
                    state_next = S_FIND;
                else
                    state_next = S_DONE;
            end
            S_ASCAN:
            begin
                if (stat.alloc_hit)
                    state_next = S_DECIDE;
                else if (stat.scan_end)
                    state_next = S_OOM;
            end
            S_FIND:
            begin
                if (stat.find_hit)
                    state_next = S_FOUND;
                else if (stat.scan_end)
                    state_next = again_reg ? S_DONE : S_BAD;
            end
            S_FOUND:
            begin
                if (stat.is_rptr && !again_reg)
                begin
                    if (stat.req_zero)
                        state_next = S_FWD_RD;
                    else if (stat.fits)
                        state_next = S_KEEP;
                    else
                        state_next = S_ASCAN;
                end
                else
                    state_next = S_FWD_RD;
            end
            S_DECIDE:   state_next = S_UP_TEST;
            S_UP_TEST:
            begin
                if (!stat.split)
                    state_next = S_WR_TAKE;
                else if (stat.up_more)
                    state_next = S_UP_RD;
                else
                    state_next = S_WR_SPLIT;
            end
            S_UP_RD:    state_next = S_UP_WR;
            S_UP_WR:    state_next = S_UP_TEST;
            S_WR_SPLIT: state_next = S_WR_TAKE;
            S_WR_TAKE:
            begin
                if (stat.is_rptr)
                begin
                    again_next = 1'b1;
                    state_next = S_FIND;
                end
                else
                    state_next = S_DONE;
            end
            S_FWD_RD:   state_next = stat.fwd_more ? S_FWD_CHK : S_BWD_RD;
            S_FWD_CHK:
            begin
                if (stat.rd_free)
                begin
                    back_next  = 1'b0;
                    state_next = S_DN_TEST;
                end
                else
                    state_next = S_BWD_RD;
            end
            S_DN_TEST:  state_next = stat.dn_more ? S_DN_RD : S_DN_DEC;
            S_DN_RD:    state_next = S_DN_WR;
            S_DN_WR:    state_next = S_DN_TEST;
            S_DN_DEC:   state_next = back_reg ? S_BWD_RD : S_FWD_RD;
            S_BWD_RD:   state_next = stat.bwd_more ? S_BWD_CHK : S_FREE_WR;
            S_BWD_CHK:
            begin
                if (stat.rd_free)
                begin
                    back_next  = 1'b1;
                    state_next = S_DN_TEST;
                end
                else
                    state_next = S_FREE_WR;
            end
            S_FREE_WR:  state_next = S_DONE;
            S_KEEP:     state_next = S_DONE;
            S_OOM:      state_next = S_DONE;
            S_BAD:      state_next = S_DONE;
            S_DONE:     state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.op = OP_NONE;
        case (state_reg)
            S_INIT:     ctl.op = OP_INIT;
            S_IDLE:     ctl.op = start ? OP_LATCH : OP_NONE;
            S_ASCAN:    ctl.op = OP_SCAN_ALLOC;
            S_FIND:     ctl.op = OP_SCAN_FIND;
            S_DECIDE:   ctl.op = OP_DECIDE;
            S_UP_RD:    ctl.op = OP_UP_RD;
            S_UP_WR:    ctl.op = OP_UP_WR;
            S_WR_SPLIT: ctl.op = OP_WR_SPLIT;
            S_WR_TAKE:  ctl.op = OP_WR_TAKE;
            S_FWD_RD:   ctl.op = OP_FWD_RD;
            S_FWD_CHK:  ctl.op = stat.rd_free ? OP_FWD_MERGE : OP_NONE;
            S_DN_RD:    ctl.op = OP_DN_RD;
            S_DN_WR:    ctl.op = OP_DN_WR;
            S_DN_DEC:   ctl.op = OP_DEC;
            S_BWD_RD:   ctl.op = OP_BWD_RD;
            S_BWD_CHK:  ctl.op = stat.rd_free ? OP_BWD_MERGE : OP_NONE;
            S_FREE_WR:  ctl.op = OP_FREE_WR;
            S_KEEP:     ctl.op = OP_RES_KEEP;
            S_OOM:      ctl.op = OP_RES_OOM;
            S_BAD:      ctl.op = OP_RES_BAD;
            default:    ctl.op = OP_NONE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

endmodule

@@ sv/ffba_dp.sv @@
// Datapath of the first-fit block allocator: block table memory, scan and shift counters,
// working block and result registers. Depends on ffba_pkg; steered by ffba_ctrl.
module ffba_dp #(
    parameter int MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffba_pkg::dp_cmd_t           ctl,
    output ffba_pkg::dp_stat_t          stat,
    input  logic [ffba_pkg::CMD_W-1:0]  cmd,
    input  logic [ffba_pkg::REQ_W-1:0]  req_bytes,
    input  logic [ffba_pkg::OFF_W-1:0]  ptr_offset,
    input  logic                        ptr_valid,
    output logic [ffba_pkg::OFF_W-1:0]  res_offset,
    output logic                        res_valid,
    output logic [ffba_pkg::STAT_W-1:0] status
);
    import ffba_pkg::*;

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int AW    = OFF_W + 1;

    entry_t blk_mem [MAX_BLOCKS];
    entry_t rd_data_reg;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;

    logic [CMD_W-1:0]  cmd_reg, cmd_next;
    logic [OFF_W-1:0]  ptr_reg, ptr_next;
    logic              pv_reg, pv_next;
    logic              rz_reg, rz_next;
    logic [WANT_W-1:0] want_reg, want_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  ri_reg, ri_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              split_reg, split_next;
    logic [OFF_W-1:0]  cur_start_reg, cur_start_next;
    logic [OFF_W-1:0]  cur_size_reg, cur_size_next;
    logic [OFF_W-1:0]  res_off_reg, res_off_next;
    logic              res_vld_reg, res_vld_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic [WANT_W-1:0] req_up;
    logic [WANT_W-1:0] want_in;
    logic              find_match;
    logic              alloc_match;
    logic              split_cond;
    logic [CNT_W-1:0]  idx_p1;
    logic [CNT_W-1:0]  ri_m1;
    logic [OFF_W-1:0]  hdr;

    assign hdr     = OFF_W'(HEADER_BYTES);
    assign req_up  = (WANT_W'(req_bytes) + WANT_W'(ALIGN_BYTES - 1))
                     & ~WANT_W'(ALIGN_BYTES - 1);
    assign want_in = (req_bytes == '0) ? WANT_W'(ALIGN_BYTES) : req_up;

    assign find_match  = ({1'b0, rd_data_reg.start} + AW'(HEADER_BYTES)) == {1'b0, ptr_reg};
    assign alloc_match = rd_data_reg.free && (WANT_W'(rd_data_reg.size) >= want_reg);
    assign split_cond  = (SUM_W'(cur_size_reg) >=
                          SUM_W'(want_reg) + SUM_W'(HEADER_BYTES + ALIGN_BYTES))
                         && (count_reg < CNT_W'(MAX_BLOCKS));
    assign idx_p1 = CNT_W'(idx_reg) + CNT_W'(1);
    assign ri_m1  = ri_reg - CNT_W'(1);

    always_comb
    begin
        stat.find_hit  = pend_reg && find_match;
        stat.alloc_hit = pend_reg && alloc_match;
        stat.scan_end  = pend_reg && (ri_reg == count_reg);
        stat.is_alloc  = (cmd_reg == CMD_ALLOC) || ((cmd_reg == CMD_REALLOC) && !pv_reg);
        stat.is_find   = ((cmd_reg == CMD_FREE) || (cmd_reg == CMD_REALLOC)) && pv_reg;
        stat.is_rptr   = (cmd_reg == CMD_REALLOC) && pv_reg;
        stat.req_zero  = rz_reg;
        stat.fits      = WANT_W'(cur_size_reg) >= want_reg;
        stat.split     = split_reg;
        stat.up_more   = j_reg > idx_p1;
        stat.dn_more   = (j_reg + CNT_W'(1)) < count_reg;
        stat.fwd_more  = idx_p1 < count_reg;
        stat.bwd_more  = idx_reg != '0;
        stat.rd_free   = rd_data_reg.free;
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        ptr_next       = ptr_reg;
        pv_next        = pv_reg;
        rz_next        = rz_reg;
        want_next      = want_reg;
        count_next     = count_reg;
        ri_next        = '0;
        pend_next      = 1'b0;
        idx_next       = idx_reg;
        j_next         = j_reg;
        split_next     = split_reg;
        cur_start_next = cur_start_reg;
        cur_size_next  = cur_size_reg;
        res_off_next   = res_off_reg;
        res_vld_next   = res_vld_reg;
        status_next    = status_reg;
        mem_we         = 1'b0;
        mem_waddr      = idx_reg;
        mem_wdata      = '{start: cur_start_reg, size: cur_size_reg, free: 1'b1};
        mem_re         = 1'b0;
        mem_raddr      = idx_reg;
        case (ctl.op)
            OP_INIT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = '{start: '0, size: OFF_W'(ARENA_BYTES - HEADER_BYTES), free: 1'b1};
                count_next = CNT_W'(1);
            end
            OP_LATCH:
            begin
                cmd_next     = cmd;
                ptr_next     = ptr_offset;
                pv_next      = ptr_valid;
                rz_next      = (req_bytes == '0);
                want_next    = want_in;
                res_off_next = '0;
                res_vld_next = 1'b0;
                status_next  = ST_OK;
            end
            OP_SCAN_ALLOC, OP_SCAN_FIND:
            begin
                ri_next   = ri_reg;
                pend_next = 1'b0;
                if (ri_reg < count_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ri_reg[IDX_W-1:0];
                    ri_next   = ri_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg && ((ctl.op == OP_SCAN_FIND) ? find_match : alloc_match))
                begin
                    idx_next       = ri_m1[IDX_W-1:0];
                    cur_start_next = rd_data_reg.start;
                    cur_size_next  = rd_data_reg.size;
                end
            end
            OP_DECIDE:
            begin
                split_next = split_cond;
                j_next     = count_reg;
            end
            OP_UP_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(j_reg - CNT_W'(1));
            end
            OP_UP_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                j_next    = j_reg - CNT_W'(1);
            end
            OP_WR_SPLIT:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_p1[IDX_W-1:0];
                mem_wdata = '{start: cur_start_reg + hdr + want_reg[OFF_W-1:0],
                              size:  cur_size_reg - want_reg[OFF_W-1:0] - hdr,
                              free:  1'b1};
            end
            OP_WR_TAKE:
            begin
                mem_we    = 1'b1;
                mem_wdata = '{start: cur_start_reg,
                              size:  split_reg ? want_reg[OFF_W-1:0] : cur_size_reg,
                              free:  1'b0};
                if (split_reg)
                    count_next = count_reg + CNT_W'(1);
                res_off_next = cur_start_reg + hdr;
                res_vld_next = 1'b1;
            end
            OP_FWD_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_p1[IDX_W-1:0];
            end
            OP_FWD_MERGE:
            begin
                cur_size_next = cur_size_reg + hdr + rd_data_reg.size;
                j_next        = idx_p1;
            end
            OP_DN_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(j_reg + CNT_W'(1));
            end
            OP_DN_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg[IDX_W-1:0];
                mem_wdata = rd_data_reg;
                j_next    = j_reg + CNT_W'(1);
            end
            OP_DEC:
            begin
                count_next = count_reg - CNT_W'(1);
            end
            OP_BWD_RD:
            begin
                mem_re    = 1'b1;
                mem_raddr = idx_reg - IDX_W'(1);
            end
            OP_BWD_MERGE:
            begin
                cur_start_next = rd_data_reg.start;
                cur_size_next  = rd_data_reg.size + hdr + cur_size_reg;
                j_next         = CNT_W'(idx_reg);
                idx_next       = idx_reg - IDX_W'(1);
            end
            OP_FREE_WR:
            begin
                mem_we = 1'b1;
            end
            OP_RES_KEEP:
            begin
                res_off_next = ptr_reg;
                res_vld_next = 1'b1;
            end
            OP_RES_OOM:  status_next = ST_OOM;
            OP_RES_BAD:  status_next = ST_BAD_PTR;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            blk_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= blk_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CNT_W'(1);
            ri_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ri_reg    <= ri_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        ptr_reg       <= ptr_next;
        pv_reg        <= pv_next;
        rz_reg        <= rz_next;
        want_reg      <= want_next;
        idx_reg       <= idx_next;
        j_reg         <= j_next;
        split_reg     <= split_next;
        cur_start_reg <= cur_start_next;
        cur_size_reg  <= cur_size_next;
        res_off_reg   <= res_off_next;
        res_vld_reg   <= res_vld_next;
        status_reg    <= status_next;
    end

    assign res_offset = res_off_reg;
    assign res_valid  = res_vld_reg;
    assign status     = status_reg;

endmodule

@@ verif/first_fit_block_allocator_core_tb.sv @@
// Testbench for first_fit_block_allocator_core: directed and random alloc/free/realloc
// traffic, checked against an in-bench model of the block table. Depends on ffba_pkg.
module first_fit_block_allocator_core_tb;
    import ffba_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int NBLK = MAX_BLOCKS_DEF;
    localparam int TAIL_CYCLES = 600;

    typedef struct {
        logic [OFF_W-1:0]  off;
        logic              valid;
        logic [STAT_W-1:0] stat;
    } alloc_result_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic                done;
    logic [CMD_W-1:0]    cmd;
    logic [REQ_W-1:0]    req_bytes;
    logic [OFF_W-1:0]    ptr_offset;
    logic                ptr_valid;
    logic [OFF_W-1:0]    res_offset;
    logic                res_valid;
    logic [STAT_W-1:0]   status;

    bit [OFF_W-1:0] tbl_start [NBLK];
    bit [OFF_W-1:0] tbl_size [NBLK];
    bit             tbl_free [NBLK];
    int             tbl_count;

    alloc_result_t  pending_results[$];
    int             error_count;
    int             send_idle_pct;

    first_fit_block_allocator_core dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .cmd(cmd), .req_bytes(req_bytes), .ptr_offset(ptr_offset), .ptr_valid(ptr_valid),
        .res_offset(res_offset), .res_valid(res_valid), .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #100000000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint round_request(longint r);
        if (r == 0)
            r = 1;
        return ((r + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    endfunction

    function automatic int find_payload(longint off);
        for (int i = 0; i < tbl_count; i++)
            if (longint'(tbl_start[i]) + HEADER_BYTES == off)
                return i;
        return -1;
    endfunction

    function automatic void drop_entry(int idx);
        for (int j = idx; j + 1 < tbl_count; j++)
        begin
            tbl_start[j] = tbl_start[j+1];
            tbl_size[j]  = tbl_size[j+1];
            tbl_free[j]  = tbl_free[j+1];
        end
        tbl_count--;
    endfunction

    function automatic bit take_first_fit(longint req, output longint off);
        longint want;
        want = round_request(req);
        off = 0;
        for (int i = 0; i < tbl_count; i++)
        begin
            if (tbl_free[i] && longint'(tbl_size[i]) >= want)
            begin
                if (longint'(tbl_size[i]) >= want + HEADER_BYTES + ALIGN_BYTES
                    && tbl_count < NBLK)
                begin
                    for (int j = tbl_count; j > i + 1; j--)
                    begin
                        tbl_start[j] = tbl_start[j-1];
                        tbl_size[j]  = tbl_size[j-1];
                        tbl_free[j]  = tbl_free[j-1];
                    end
                    tbl_start[i+1] = OFF_W'(longint'(tbl_start[i]) + HEADER_BYTES + want);
                    tbl_size[i+1]  = OFF_W'(longint'(tbl_size[i]) - want - HEADER_BYTES);
                    tbl_free[i+1]  = 1'b1;
                    tbl_size[i]    = OFF_W'(want);
                    tbl_count++;
                end
                tbl_free[i] = 1'b0;
                off = longint'(tbl_start[i]) + HEADER_BYTES;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void release_and_merge(int i);
        tbl_free[i] = 1'b1;
        while (i + 1 < tbl_count && tbl_free[i+1])
        begin
            tbl_size[i] = OFF_W'(longint'(tbl_size[i]) + HEADER_BYTES + tbl_size[i+1]);
            drop_entry(i + 1);
        end
        while (i > 0 && tbl_free[i-1])
        begin
            tbl_size[i-1] = OFF_W'(longint'(tbl_size[i-1]) + HEADER_BYTES + tbl_size[i]);
            drop_entry(i);
            i--;
        end
    endfunction

    function automatic alloc_result_t predict_alloc(logic [CMD_W-1:0] c, longint req,
                                                    longint ptr, bit pv);
        alloc_result_t r;
        longint off;
        int idx;
        r.off = '0;
        r.valid = 1'b0;
        r.stat = ST_OK;
        off = 0;
        if (c == CMD_ALLOC || (c == CMD_REALLOC && !pv))
        begin
            if (take_first_fit(req, off))
                r.valid = 1'b1;
            else
                r.stat = ST_OOM;
        end
        else if (c == CMD_FREE)
        begin
            if (pv)
            begin
                idx = find_payload(ptr);
                if (idx < 0)
                    r.stat = ST_BAD_PTR;
                else
                    release_and_merge(idx);
            end
        end
        else if (c == CMD_REALLOC)
        begin
            idx = find_payload(ptr);
            if (idx < 0)
                r.stat = ST_BAD_PTR;
            else if (req == 0)
                release_and_merge(idx);
            else if (longint'(tbl_size[idx]) >= round_request(req))
            begin
                off = ptr;
                r.valid = 1'b1;
            end
            else if (take_first_fit(req, off))
            begin
                r.valid = 1'b1;
                idx = find_payload(ptr);
                if (idx >= 0)
                    release_and_merge(idx);
            end
            else
                r.stat = ST_OOM;
        end
        if (r.valid)
            r.off = off[OFF_W-1:0];
        return r;
    endfunction

    // Pick the payload offset of a random block, preferring blocks in use if want_used, else free ones.
    function automatic logic [OFF_W-1:0] pick_block(bit want_used);
        int cand[$];
        for (int i = 0; i < tbl_count; i++)
            if (tbl_free[i] != want_used)
                cand.push_back(i);
        if (cand.size() == 0)
            return OFF_W'(longint'(tbl_start[$urandom_range(tbl_count - 1)]) + HEADER_BYTES);
        return OFF_W'(longint'(tbl_start[cand[$urandom_range(cand.size() - 1)]])
                      + HEADER_BYTES);
    endfunction

    task automatic send_command(logic [CMD_W-1:0] c, logic [REQ_W-1:0] req,
                                logic [OFF_W-1:0] ptr, logic pv, output alloc_result_t r);
        int gap;
        @(negedge clk);
        cmd        = c;
        req_bytes  = req;
        ptr_offset = ptr;
        ptr_valid  = pv;
        start      = 1'b1;
        do
            @(posedge clk);
        while (busy);
        r = predict_alloc(c, req, ptr, pv);
        pending_results.push_back(r);
        if ($urandom_range(99) < send_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain_results();
        @(negedge clk);
        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", res_offset, 0);
            else
            begin
                e = pending_results.pop_front();
                if (res_valid !== e.valid)
                    report_mismatch("res_valid", res_valid, e.valid);
                if (res_offset !== e.off)
                    report_mismatch("res_offset", res_offset, e.off);
                if (status !== e.stat)
                    report_mismatch("status", status, e.stat);
            end
        end
    end

    task automatic test_basic_alloc_free();
        alloc_result_t a, b, r;
        send_command(CMD_ALLOC, 21'd0, '0, 1'b0, a);
        send_command(CMD_ALLOC, 21'd100, 20'hFFFFF, 1'b1, b);
        send_command(CMD_ALLOC, 21'd1048576, '0, 1'b0, r);
        send_command(CMD_FREE, 21'd0, b.off, 1'b1, r);
        send_command(CMD_FREE, 21'd0, b.off, 1'b1, r);
        send_command(CMD_ALLOC, 21'd1048000, '0, 1'b0, r);
        send_command(CMD_FREE, 21'd0, r.off, 1'b1, r);
        send_command(CMD_FREE, 21'd0, a.off, 1'b1, r);
        send_command(CMD_ALLOC, 21'd1048544, '0, 1'b0, a);
        send_command(CMD_FREE, 21'd0, a.off, 1'b1, r);
        drain_results();
    endtask

    task automatic test_special_cases();
        alloc_result_t r;
        send_command(CMD_FREE, 21'd5, '0, 1'b0, r);
        send_command(CMD_FREE, 21'd0, 20'd5, 1'b1, r);
        send_command(CMD_FREE, 21'h1FFFFF, 20'hFFFFF, 1'b1, r);
        send_command(CMD_UNUSED, 21'd64, 20'd32, 1'b1, r);
        send_command(CMD_REALLOC, 21'd16, 20'd7, 1'b1, r);
        drain_results();
    endtask

    task automatic test_realloc();
        alloc_result_t c, d, r;
        send_command(CMD_REALLOC, 21'd40, '0, 1'b0, c);
        send_command(CMD_REALLOC, 21'd10, c.off, 1'b1, r);
        send_command(CMD_REALLOC, 21'd5000, c.off, 1'b1, d);
        send_command(CMD_REALLOC, 21'd1048576, d.off, 1'b1, r);
        send_command(CMD_REALLOC, 21'd0, d.off, 1'b1, r);
        send_command(CMD_REALLOC, 21'd32, 20'd32, 1'b1, r);
        drain_results();
    endtask

    task automatic test_random_traffic(int count, int idle_pct);
        alloc_result_t r;
        logic [CMD_W-1:0] c;
        logic [REQ_W-1:0] req;
        logic [OFF_W-1:0] ptr;
        logic pv;
        int sel;
        send_idle_pct = idle_pct;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(99);
            req = (sel % 10 == 0) ? REQ_W'($urandom_range(0, 1048576))
                                  : REQ_W'($urandom_range(0, 3000));
            if (sel % 37 == 0)
                req = 21'd1048576;
            ptr = OFF_W'($urandom);
            pv  = 1'b1;
            if (sel < 42)
            begin
                c = CMD_ALLOC;
                pv = 1'($urandom_range(1));
            end
            else if (sel < 72)
            begin
                c = CMD_FREE;
                ptr = pick_block(1'b1);
            end
            else if (sel < 88)
            begin
                c = CMD_REALLOC;
                ptr = pick_block(1'b1);
                if (sel % 8 == 0)
                    req = '0;
            end
            else if (sel < 91)
            begin
                c = ($urandom_range(1)) ? CMD_FREE : CMD_REALLOC;
                ptr = pick_block(1'b0);
            end
            else if (sel < 94)
                c = CMD_UNUSED;
            else if (sel < 97)
            begin
                c = ($urandom_range(1)) ? CMD_FREE : CMD_REALLOC;
                pv = 1'b0;
            end
            else
                c = ($urandom_range(1)) ? CMD_FREE : CMD_REALLOC;
            send_command(c, req, ptr, pv, r);
        end
        drain_results();
    endtask

    initial
    begin
        for (int i = 0; i < NBLK; i++)
        begin
            tbl_start[i] = '0;
            tbl_size[i]  = '0;
            tbl_free[i]  = 1'b0;
        end
        tbl_size[0]   = OFF_W'(ARENA_BYTES - HEADER_BYTES);
        tbl_free[0]   = 1'b1;
        tbl_count     = 1;
        error_count   = 0;
        send_idle_pct = 0;
        rst_n      = 1'b0;
        start      = 1'b0;
        cmd        = CMD_ALLOC;
        req_bytes  = '0;
        ptr_offset = '0;
        ptr_valid  = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_basic_alloc_free();
        test_special_cases();
        test_realloc();
        test_random_traffic(520, 28);
        test_random_traffic(515, 46);
        test_random_traffic(515, 0);

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
